// ===== design/s2dp_pkg.sv =====
// Shared constants and types for the Stirling number (second kind) block.
// No dependencies; imported by every design file.
package s2dp_pkg;

    localparam int MAX_K     = 64;
    localparam int N_WIDTH   = 16;
    localparam int K_WIDTH   = 7;
    localparam int MOD_WIDTH = 31;

    localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(1000000007);

    localparam int COL_W  = $clog2(MAX_K + 1);
    localparam int BIT_W  = (COL_W > 1) ? $clog2(COL_W) : 1;
    localparam int CMP_W  = (N_WIDTH > K_WIDTH) ? N_WIDTH : K_WIDTH;
    localparam int IN_W   = ((N_WIDTH + K_WIDTH + 7) / 8) * 8;
    localparam int OUT_W  = ((MOD_WIDTH + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

endpackage

// ===== design/s2dp_modstep.sv =====
// Modular step unit: r = (a or 2a) + b reduced mod p, with a, b < p.
// Depends on s2dp_pkg.
module s2dp_modstep
    import s2dp_pkg::*;
(
    input  logic [MOD_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0] b,
    input  logic [MOD_WIDTH-1:0] p,
    input  logic                 dbl,
    output logic [MOD_WIDTH-1:0] r
);

    logic [MOD_WIDTH+1:0] t;
    logic [MOD_WIDTH+1:0] p1;
    logic [MOD_WIDTH+1:0] p2;

    always_comb
    begin
        p1 = (MOD_WIDTH+2)'(p);
        p2 = p1 << 1;
        t  = (dbl ? ((MOD_WIDTH+2)'(a) << 1) : (MOD_WIDTH+2)'(a)) + (MOD_WIDTH+2)'(b);
        if (t >= p2)
        begin
            r = MOD_WIDTH'(t - p2);
        end
        else if (t >= p1)
        begin
            r = MOD_WIDTH'(t - p1);
        end
        else
        begin
            r = MOD_WIDTH'(t);
        end
    end

endmodule

// ===== design/stirling2_dp_mod_prime.sv =====
// S(n,k) mod p: row-by-row DP over a 65-entry row store with one shared modular step unit.
// Base cases (n<k, n==k, k==0, k>MAX_K) answer in the cycle after the input beat.
// DP path: each cell takes 7 double-and-add steps for j*S plus 1 add on the shared unit.
// One query at a time.
// Reset: modulus returns to 1000000007, no result pending; the row store needs no sweep.
// Depends on s2dp_pkg and s2dp_modstep.
module stirling2_dp_mod_prime
    import s2dp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // query_n, query_k, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // stirling_value, zero pad
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MOD_WIDTH-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] p;
    logic [MOD_WIDTH-1:0] one_val;

    logic [N_WIDTH-1:0]   n_reg;
    logic [N_WIDTH-1:0]   i_reg;
    logic [COL_W-1:0]     k_reg;
    logic [COL_W-1:0]     j_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] hi_reg;
    logic [MOD_WIDTH-1:0] lo_reg;
    logic [MOD_WIDTH-1:0] col0_reg;
    logic [MOD_WIDTH-1:0] res_reg;
    logic [MOD_WIDTH-1:0] m_data_reg;
    logic                 m_tvalid_reg;
    logic [MAX_K:1]       valid_reg;

    logic [MOD_WIDTH-1:0] mem [0:MAX_K];
    logic [MOD_WIDTH-1:0] rd_mem_reg;
    logic                 rd_ok_reg;
    logic                 rd_col0_reg;
    logic [MOD_WIDTH-1:0] rd_val;

    logic                 rd_en;
    logic [COL_W-1:0]     rd_addr;
    logic                 wr_en;

    logic [N_WIDTH-1:0]   q_n;
    logic [K_WIDTH-1:0]   q_k;
    logic [CMP_W-1:0]     nx;
    logic [CMP_W-1:0]     kx;
    logic                 accept;
    logic                 out_free;
    logic                 is_base;
    logic [MOD_WIDTH-1:0] base_val;
    logic [COL_W-1:0]     top;

    logic [MOD_WIDTH-1:0] st_b;
    logic                 st_dbl;
    logic [MOD_WIDTH-1:0] st_r;

    assign p        = (modulus_reg > MOD_WIDTH'(1)) ? modulus_reg : MOD_WIDTH'(1);
    assign one_val  = (modulus_reg > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;

    assign q_n      = s_tdata[N_WIDTH-1:0];
    assign q_k      = s_tdata[N_WIDTH+K_WIDTH-1:N_WIDTH];
    assign nx       = CMP_W'(q_n);
    assign kx       = CMP_W'(q_k);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_base  = (nx <= kx) || (q_k == '0) || (32'(q_k) > 32'(MAX_K));
    assign base_val = (nx == kx) ? one_val : '0;

    assign top      = (32'(i_reg) < 32'(k_reg)) ? COL_W'(i_reg) : k_reg;
    assign rd_val   = rd_col0_reg ? col0_reg : (rd_ok_reg ? rd_mem_reg : '0);

    assign st_b     = (state_reg == S_MUL) ? (j_reg[bit_reg] ? hi_reg : '0) : lo_reg;
    assign st_dbl   = (state_reg == S_MUL);

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_W'(m_data_reg);
    assign cfg_ready = 1'b1;

    s2dp_modstep u_step (
        .a   (acc_reg),
        .b   (st_b),
        .p   (p),
        .dbl (st_dbl),
        .r   (st_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_base)
                begin
                    state_next = S_RD_HI;
                end
            end
            S_RD_HI:
            begin
                rd_en      = 1'b1;
                rd_addr    = top;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg - COL_W'(1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                wr_en = 1'b1;
                if (j_reg == COL_W'(1))
                begin
                    state_next = (i_reg == n_reg) ? S_DONE : S_RD_HI;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg - COL_W'(2);
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // row store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[j_reg] <= st_r;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_RESET;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            rd_ok_reg    <= 1'b0;
            rd_col0_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                modulus_reg <= cfg_data;
            end
            if (rd_en)
            begin
                rd_col0_reg <= (rd_addr == '0);
                rd_ok_reg   <= (rd_addr != '0) && valid_reg[rd_addr];
            end
            if (state_reg == S_IDLE && accept && !is_base)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[j_reg] <= 1'b1;
            end
            if (state_reg == S_IDLE && accept && is_base)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_base)
                    begin
                        m_data_reg <= base_val;
                    end
                    else
                    begin
                        n_reg    <= q_n;
                        k_reg    <= COL_W'(q_k);
                        i_reg    <= N_WIDTH'(1);
                        col0_reg <= one_val;
                    end
                end
            end
            S_RD_HI:
            begin
                j_reg <= top;
            end
            S_RD_LO:
            begin
                hi_reg  <= rd_val;
                acc_reg <= '0;
                bit_reg <= BIT_W'(COL_W - 1);
            end
            S_MUL:
            begin
                if (bit_reg == BIT_W'(COL_W - 1))
                begin
                    lo_reg <= rd_val;
                end
                acc_reg <= st_r;
                bit_reg <= bit_reg - BIT_W'(1);
            end
            S_ADD:
            begin
                if (j_reg == k_reg)
                begin
                    res_reg <= st_r;
                end
                if (j_reg == COL_W'(1))
                begin
                    col0_reg <= '0;
                    i_reg    <= i_reg + N_WIDTH'(1);
                end
                else
                begin
                    j_reg   <= j_reg - COL_W'(1);
                    hi_reg  <= lo_reg;
                    acc_reg <= '0;
                    bit_reg <= BIT_W'(COL_W - 1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_data_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/s2dp_checker.sv =====
// Port-level checks for stirling2_dp_mod_prime, attached by the bind at the end.
// Depends on s2dp_pkg.
module s2dp_checker
    import s2dp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [CMP_W-1:0] cn;
    logic [CMP_W-1:0] ck;
    logic             in_beat;
    logic             zero_case;
    logic             dp_case;

    assign cn        = CMP_W'(s_tdata[N_WIDTH-1:0]);
    assign ck        = CMP_W'(s_tdata[N_WIDTH+K_WIDTH-1:N_WIDTH]);
    assign in_beat   = s_tvalid && s_tready;
    assign zero_case = (cn < ck) || ((ck == '0) && (cn != '0));
    assign dp_case   = (cn > ck) && (ck != '0) && (32'(ck) <= 32'(MAX_K));

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_zero_case: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && zero_case |=> m_tvalid && (m_tdata == '0))
        else $error("trivial zero query not answered next cycle");

    a_diag_case: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (cn == ck) |=> m_tvalid && (m_tdata[OUT_W-1:1] == '0))
        else $error("n equal k query not answered with 0 or 1");

    a_dp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && dp_case |=> !s_tready && !m_tvalid)
        else $error("block ready or answering right after a recurrence query");

endmodule

bind stirling2_dp_mod_prime s2dp_checker u_s2dp_checker (.*);
